// ===== src/bse_pkg.sv =====
package bse_pkg;

    // Defaults for the top-level parameters
    localparam int COORD_WIDTH_DEF  = 32;
    localparam int MAX_SEGMENTS_DEF = 63;

    // Fixed widths
    localparam int IDX_W     = 6;   // segment count and sample index
    localparam int WGT_W     = 21;  // basis weights and divisor D = 6N^3 (at most 1500282)
    localparam int CALC_W    = 24;  // signed headroom for the weight sums
    localparam int ACC_EXTRA = 24;  // accumulator bits above COORD_WIDTH

    // Input item layout
    localparam int N_CTRL   = 8;    // c0_x .. c3_y
    localparam int N_PIN    = 4;    // start_x, start_y, end_x, end_y
    localparam int N_FIELDS = N_CTRL + N_PIN;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SEGMENTS      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CUBIC_MODE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIN_ENDPOINTS = 8'd2;

    localparam logic [IDX_W-1:0] SEGMENTS_RESET = 6'd16;

    typedef logic [WGT_W-1:0] wgt_t;

    // Weights of one sample point plus the common divisor
    typedef struct packed {
        wgt_t w0;
        wgt_t w1;
        wgt_t w2;
        wgt_t w3;
        wgt_t d;
    } wgt_set_t;

    // Sequencer controls toward the multiply-accumulate unit
    typedef struct packed {
        logic load;
        logic step;
        logic hi_sel;
    } mac_ctrl_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== src/bspline_segment_evaluator.sv =====
// Uniform B-spline segment evaluator. One request on the s_ channel carries
// a segment (four Q16.16 control points, or the first three in quadratic
// mode, plus start and end points used when endpoint pinning is on) and
// yields N+1 curve points at t = i/N on the m_ channel, the last with tlast
// set. Each point is the exact weighted sum of the control points divided by
// D and rounded to nearest, ties upward. The block takes one segment at a
// time and is not ready while it works. The work per point is set by the
// bit-serial divider, run once per coordinate, and by the single shared
// multiplier doing two partial products per control point. Configuration
// writes take effect for the next segment and are accepted at any time.
module bspline_segment_evaluator #(
    parameter int COORD_WIDTH  = bse_pkg::COORD_WIDTH_DEF,
    parameter int MAX_SEGMENTS = bse_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    // c0_x, c0_y, c1_x, c1_y, c2_x, c2_y, c3_x, c3_y, start_x, start_y,
    // end_x, end_y (lowest bit up), zero padded to whole bytes
    input  logic [((bse_pkg::N_FIELDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,

    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_x, out_y, sample_index (lowest bit up), zero padded to whole bytes
    output logic [((2*COORD_WIDTH+bse_pkg::IDX_W+7)/8)*8-1:0] m_tdata,
    output logic                               m_tlast,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bse_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bse_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ACC_W      = COORD_WIDTH + bse_pkg::ACC_EXTRA;
    localparam int IDX_W      = bse_pkg::IDX_W;
    localparam int M_FIELDS_W = 2 * COORD_WIDTH + IDX_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic [2:0] CNT_LAST_CUBIC = 3'd7;
    localparam logic [2:0] CNT_LAST_QUAD  = 3'd5;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_WGT   = 8'b0000_0010,
        ST_LOAD  = 8'b0000_0100,
        ST_MAC   = 8'b0000_1000,
        ST_DRAIN = 8'b0001_0000,
        ST_DIVGO = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [IDX_W-1:0] seg_reg;
    logic             cubic_cfg_reg;
    logic             pin_cfg_reg;

    // Current segment
    logic [COORD_WIDTH-1:0] ctrl_pt_reg [bse_pkg::N_CTRL];
    logic [COORD_WIDTH-1:0] pin_pt_reg  [bse_pkg::N_PIN];
    logic [IDX_W-1:0]       n_reg;
    logic                   cubic_reg;
    logic                   pin_reg;

    // Sequencer counters
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             axis_reg, axis_next;
    logic [2:0]       cnt_reg, cnt_next;
    logic [2:0]       cnt_last;

    logic [COORD_WIDTH-1:0] x_res_reg;

    // Output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    logic                   accept;
    logic [IDX_W-1:0]       n_eff;
    logic                   wgt_start;
    logic                   wgt_done;
    bse_pkg::wgt_set_t      wgt_set;
    logic [ACC_W-1:0]       bias;
    bse_pkg::mac_ctrl_t     mac_ctrl;
    bse_pkg::wgt_t          mac_wgt;
    logic [ACC_W-1:0]       acc;
    logic                   div_start;
    bse_pkg::div_stat_t     div_stat;
    logic [COORD_WIDTH-1:0] div_quo;
    logic                   out_load;
    logic [COORD_WIDTH-1:0] out_x, out_y;
    logic                   at_last;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg       <= bse_pkg::SEGMENTS_RESET;
            cubic_cfg_reg <= 1'b1;
            pin_cfg_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == bse_pkg::REG_SEGMENTS) begin
                seg_reg <= cfg_data[IDX_W-1:0];
            end else if (cfg_index == bse_pkg::REG_CUBIC_MODE) begin
                cubic_cfg_reg <= cfg_data[0];
            end else if (cfg_index == bse_pkg::REG_PIN_ENDPOINTS) begin
                pin_cfg_reg <= cfg_data[0];
            end
        end
    end

    // Effective interval count: zero reads as one, capped at the maximum
    always_comb begin
        priority if (seg_reg == '0) begin
            n_eff = IDX_W'(1);
        end else if (int'(seg_reg) > MAX_SEGMENTS) begin
            n_eff = IDX_W'(MAX_SEGMENTS);
        end else begin
            n_eff = seg_reg;
        end
    end

    // Capture the segment and the settings it runs with
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < bse_pkg::N_CTRL; k++) begin
                ctrl_pt_reg[k] <= s_tdata[k*COORD_WIDTH +: COORD_WIDTH];
            end
            for (int k = 0; k < bse_pkg::N_PIN; k++) begin
                pin_pt_reg[k] <= s_tdata[(bse_pkg::N_CTRL + k)*COORD_WIDTH +: COORD_WIDTH];
            end
            n_reg     <= n_eff;
            cubic_reg <= cubic_cfg_reg;
            pin_reg   <= pin_cfg_reg;
        end
    end

    assign cnt_last = cubic_reg ? CNT_LAST_CUBIC : CNT_LAST_QUAD;
    assign at_last  = (idx_reg == n_reg);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        axis_next  = axis_reg;
        cnt_next   = cnt_reg;
        wgt_start  = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        mac_ctrl.load   = 1'b0;
        mac_ctrl.step   = 1'b0;
        mac_ctrl.hi_sel = cnt_reg[0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    idx_next   = '0;
                    wgt_start  = 1'b1;
                    state_next = ST_WGT;
                end
            end
            ST_WGT: begin
                if (wgt_done) begin
                    axis_next  = 1'b0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                mac_ctrl.load = 1'b1;
                cnt_next      = '0;
                state_next    = ST_MAC;
            end
            ST_MAC: begin
                mac_ctrl.step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == cnt_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DIVGO;
            end
            ST_DIVGO: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (!axis_reg) begin
                        axis_next  = 1'b1;
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load = 1'b1;
                    if (at_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        wgt_start  = 1'b1;
                        state_next = ST_WGT;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            axis_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            axis_reg  <= axis_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Weight for the current term
    always_comb begin
        unique case (cnt_reg[2:1])
            2'd0:    mac_wgt = wgt_set.w0;
            2'd1:    mac_wgt = wgt_set.w1;
            2'd2:    mac_wgt = wgt_set.w2;
            default: mac_wgt = wgt_set.w3;
        endcase
    end

    bse_weights #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_weights (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (wgt_start),
        .idx     (idx_reg),
        .n       (n_reg),
        .cubic   (cubic_reg),
        .wgt     (wgt_set),
        .bias    (bias),
        .done    (wgt_done)
    );

    bse_mac #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mac_ctrl),
        .load_val (bias),
        .coord    (ctrl_pt_reg[{cnt_reg[2:1], axis_reg}]),
        .wgt      (mac_wgt),
        .acc      (acc)
    );

    bse_div #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (acc),
        .den     (wgt_set.d),
        .stat    (div_stat),
        .quo     (div_quo)
    );

    // Hold the x result while y is computed
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DIV) && div_stat.done && !axis_reg) begin
            x_res_reg <= div_quo;
        end
    end

    // Pinned endpoints replace the first and last points
    always_comb begin
        priority if (pin_reg && (idx_reg == '0)) begin
            out_x = pin_pt_reg[0];
            out_y = pin_pt_reg[1];
        end else if (pin_reg && at_last) begin
            out_x = pin_pt_reg[2];
            out_y = pin_pt_reg[3];
        end else begin
            out_x = x_res_reg;
            out_y = div_quo;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= M_TDATA_W'({idx_reg, out_y, out_x});
            m_tlast_reg <= at_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Checks
    a_accept_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a segment is in progress");

    a_wgt_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        wgt_done |-> (state_reg == ST_WGT))
        else $error("weights finished outside the weight wait");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide wait");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVGO) |-> !div_stat.busy)
        else $error("divider restarted while busy");

endmodule

// ===== src/bse_weights.sv =====
// Basis weight generator: a short register pipeline that forms the
// integer weights for sample i, the divisor D and the rounding bias.
module bse_weights #(
    parameter int COORD_WIDTH = bse_pkg::COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bse_pkg::IDX_W-1:0]     idx,
    input  logic [bse_pkg::IDX_W-1:0]     n,
    input  logic                          cubic,
    output bse_pkg::wgt_set_t             wgt,
    output logic [COORD_WIDTH+bse_pkg::ACC_EXTRA-1:0] bias,
    output logic                          done
);

    localparam int ACC_W = COORD_WIDTH + bse_pkg::ACC_EXTRA;
    localparam int CW    = bse_pkg::CALC_W;

    localparam logic signed [CW-1:0] K2 = 24'sd2;
    localparam logic signed [CW-1:0] K3 = 24'sd3;
    localparam logic signed [CW-1:0] K4 = 24'sd4;
    localparam logic signed [CW-1:0] K6 = 24'sd6;

    logic [4:0]  vld_reg;

    logic [5:0]  s1_i_reg, s1_j_reg, s1_n_reg;
    logic [11:0] s1_sqi_reg, s1_sqj_reg, s1_sqn_reg, s1_in_reg;

    logic [11:0] s2_sqi_reg, s2_sqj_reg, s2_sqn_reg, s2_in_reg;
    logic [17:0] s2_cui_reg, s2_cuj_reg, s2_cun_reg, s2_i2n_reg, s2_in2_reg;

    bse_pkg::wgt_set_t wgt_reg, wgt_next;
    logic [ACC_W-1:0]  bias_reg;

    logic signed [CW-1:0] ci, cn, i2n, in2, sqi, sqn, inq;
    logic signed [CW-1:0] w1c, w2c, w1q;

    // Valid marker travels alongside the data stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], start};
        end
    end

    // Stage 1: squares and i*N
    always_ff @(posedge aclk) begin
        s1_i_reg   <= idx;
        s1_j_reg   <= n - idx;
        s1_n_reg   <= n;
        s1_sqi_reg <= 12'(idx) * 12'(idx);
        s1_sqj_reg <= 12'(n - idx) * 12'(n - idx);
        s1_sqn_reg <= 12'(n) * 12'(n);
        s1_in_reg  <= 12'(idx) * 12'(n);
    end

    // Stage 2: cubes and mixed terms
    always_ff @(posedge aclk) begin
        s2_sqi_reg <= s1_sqi_reg;
        s2_sqj_reg <= s1_sqj_reg;
        s2_sqn_reg <= s1_sqn_reg;
        s2_in_reg  <= s1_in_reg;
        s2_cui_reg <= 18'(s1_sqi_reg) * 18'(s1_i_reg);
        s2_cuj_reg <= 18'(s1_sqj_reg) * 18'(s1_j_reg);
        s2_cun_reg <= 18'(s1_sqn_reg) * 18'(s1_n_reg);
        s2_i2n_reg <= 18'(s1_sqi_reg) * 18'(s1_n_reg);
        s2_in2_reg <= 18'(s1_i_reg) * 18'(s1_sqn_reg);
    end

    // Stage 3: weight sums; intermediates signed, final weights never negative
    always_comb begin
        ci  = CW'(s2_cui_reg);
        cn  = CW'(s2_cun_reg);
        i2n = CW'(s2_i2n_reg);
        in2 = CW'(s2_in2_reg);
        sqi = CW'(s2_sqi_reg);
        sqn = CW'(s2_sqn_reg);
        inq = CW'(s2_in_reg);

        w1c = K3 * ci - K6 * i2n + K4 * cn;
        w2c = K3 * i2n + K3 * in2 + cn - K3 * ci;
        w1q = K2 * inq + sqn - K2 * sqi;

        if (cubic) begin
            wgt_next.w0 = bse_pkg::WGT_W'(s2_cuj_reg);
            wgt_next.w1 = bse_pkg::WGT_W'(w1c);
            wgt_next.w2 = bse_pkg::WGT_W'(w2c);
            wgt_next.w3 = bse_pkg::WGT_W'(s2_cui_reg);
            wgt_next.d  = bse_pkg::WGT_W'(K6 * cn);
        end else begin
            wgt_next.w0 = bse_pkg::WGT_W'(s2_sqj_reg);
            wgt_next.w1 = bse_pkg::WGT_W'(w1q);
            wgt_next.w2 = bse_pkg::WGT_W'(s2_sqi_reg);
            wgt_next.w3 = '0;
            wgt_next.d  = bse_pkg::WGT_W'(K2 * sqn);
        end
    end

    always_ff @(posedge aclk) begin
        wgt_reg <= wgt_next;
    end

    // Stage 4: accumulator start value D/2 + D*2^(W-1); D is always even.
    // It folds the round-half-up offset and a shift to a non-negative range.
    always_ff @(posedge aclk) begin
        bias_reg <= (ACC_W'(wgt_reg.d) << (COORD_WIDTH - 1)) + ACC_W'(wgt_reg.d >> 1);
    end

    assign wgt  = wgt_reg;
    assign bias = bias_reg;
    assign done = vld_reg[4];

endmodule

// ===== src/bse_mac.sv =====
// Shared multiply-accumulate unit. Each step multiplies one half of a
// coordinate by one weight; the product is registered, then shifted into
// place and added to the accumulator on the next cycle.
module bse_mac #(
    parameter int COORD_WIDTH = bse_pkg::COORD_WIDTH_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  bse_pkg::mac_ctrl_t                         ctrl,
    input  logic [COORD_WIDTH+bse_pkg::ACC_EXTRA-1:0]  load_val,
    input  logic [COORD_WIDTH-1:0]                     coord,
    input  bse_pkg::wgt_t                              wgt,
    output logic [COORD_WIDTH+bse_pkg::ACC_EXTRA-1:0]  acc
);

    localparam int ACC_W = COORD_WIDTH + bse_pkg::ACC_EXTRA;
    localparam int LO_W  = COORD_WIDTH / 2;
    localparam int HI_W  = COORD_WIDTH - LO_W;
    localparam int A_W   = HI_W + 1;
    localparam int P_W   = A_W + bse_pkg::WGT_W + 1;

    logic signed [A_W-1:0]   oper_a;
    logic signed [P_W-1:0]   prod_c;
    logic signed [P_W-1:0]   prod_reg;
    logic                    prod_hi_reg;
    logic                    prod_vld_reg;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] acc_reg;

    // Operand: signed upper half or zero-extended lower half
    always_comb begin
        if (ctrl.hi_sel) begin
            oper_a = {coord[COORD_WIDTH-1], coord[COORD_WIDTH-1:LO_W]};
        end else begin
            oper_a = {{(A_W - LO_W){1'b0}}, coord[LO_W-1:0]};
        end
        prod_c = oper_a * $signed({1'b0, wgt});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctrl.step;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg    <= prod_c;
        prod_hi_reg <= ctrl.hi_sel;
    end

    // Align the partial product and accumulate
    always_comb begin
        if (prod_hi_reg) begin
            term = ACC_W'(prod_reg) <<< LO_W;
        end else begin
            term = ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            acc_reg <= $signed(load_val);
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + term;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== src/bse_div.sv =====
// Restoring divider, one quotient bit per cycle. The dividend is the
// biased accumulator, known to be below D * 2^W, so the quotient fits in
// W bits; flipping its top bit undoes the bias and gives the signed point.
module bse_div #(
    parameter int COORD_WIDTH = bse_pkg::COORD_WIDTH_DEF
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       start,
    input  logic [COORD_WIDTH+bse_pkg::ACC_EXTRA-1:0]  num,
    input  bse_pkg::wgt_t                              den,
    output bse_pkg::div_stat_t                         stat,
    output logic [COORD_WIDTH-1:0]                     quo
);

    localparam int CNT_W = $clog2(COORD_WIDTH + 1);
    localparam int REM_W = bse_pkg::WGT_W + 1;

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [REM_W-1:0]       rem_reg;
    logic [COORD_WIDTH-1:0] quo_reg;
    bse_pkg::wgt_t          den_reg;

    logic [REM_W-1:0]       rem_sh;
    logic                   ge;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        rem_sh = {rem_reg[REM_W-2:0], quo_reg[COORD_WIDTH-1]};
        ge     = rem_sh >= {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(COORD_WIDTH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= REM_W'(num[COORD_WIDTH +: bse_pkg::WGT_W]);
            quo_reg <= num[COORD_WIDTH-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            quo_reg <= {quo_reg[COORD_WIDTH-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = {~quo_reg[COORD_WIDTH-1], quo_reg[COORD_WIDTH-2:0]};

endmodule

// ===== sim/bspline_segment_evaluator_tb.sv =====
`timescale 1ns / 1ps

module bspline_segment_evaluator_tb;

    localparam int CW           = bse_pkg::COORD_WIDTH_DEF;
    localparam int MAX_SEG      = bse_pkg::MAX_SEGMENTS_DEF;
    localparam int N_FIELDS     = bse_pkg::N_FIELDS;
    localparam int N_CTRL       = bse_pkg::N_CTRL;
    localparam int IDX_W        = bse_pkg::IDX_W;
    localparam int CFG_IDX_W    = bse_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = bse_pkg::CFG_DATA_W;
    localparam int S_W          = ((N_FIELDS * CW + 7) / 8) * 8;
    localparam int M_W          = ((2 * CW + IDX_W + 7) / 8) * 8;
    localparam int SETTLE_CYCLES = 120;      // about one point's worth of work
    localparam int END_CYCLES    = 300;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 11;

    // indexes outside the register map, writes there must do nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 8'hFF;

    localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_SEGMENT,
        OP_REG_WRITE,
        OP_DRAIN
    } plan_kind_t;

    typedef struct packed {
        plan_kind_t                  kind;
        logic [N_FIELDS*CW-1:0]      fields;
        logic [CFG_IDX_W-1:0]        reg_idx;
        logic [CFG_DATA_W-1:0]       reg_val;
    } plan_entry_t;

    typedef struct packed {
        logic [CW-1:0]    x;
        logic [CW-1:0]    y;
        logic [IDX_W-1:0] idx;
        logic             is_last;
    } curve_point_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_W-1:0]        s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_W-1:0]        m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    plan_entry_t  request_plan[$];
    curve_point_t pending_points[$];

    // shadow of the block's registers
    logic [IDX_W-1:0] shadow_segments = bse_pkg::SEGMENTS_RESET;
    logic             shadow_cubic    = 1'b1;
    logic             shadow_pin      = 1'b0;

    int total_items    = 0;
    int items_accepted = 0;
    int settle_cnt     = 0;
    int error_count    = 0;
    int cycle_count    = 0;

    bspline_segment_evaluator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic log_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Idle percentage per side: sender light / receiver heavy, then swapped, then none
    function automatic int idle_pct(input bit sender);
        if (items_accepted < total_items / 3)
            return sender ? 17 : 84;
        else if (items_accepted < (2 * total_items) / 3)
            return sender ? 84 : 17;
        return 0;
    endfunction

    // floor((2*acc + div) / (2*div)): nearest, ties toward +inf; then clamp
    function automatic logic [CW-1:0] round_to_coord(input longint acc, input longint div);
        longint num, den, q, lo_lim, hi_lim;
        num    = 2 * acc + div;
        den    = 2 * div;
        q      = num / den;
        if ((num % den != 0) && (num < 0))
            q--;
        hi_lim = (longint'(1) << (CW - 1)) - 1;
        lo_lim = -hi_lim - 1;
        if (q < lo_lim) q = lo_lim;
        if (q > hi_lim) q = hi_lim;
        return q[CW-1:0];
    endfunction

    // Expected curve points of one segment under the current register values
    task automatic predict_curve_points(input logic [N_FIELDS*CW-1:0] f);
        longint nseg, d, i, j, acc_x, acc_y;
        longint w [4];
        logic signed [CW-1:0] cx, cy;
        int nctl, k;
        curve_point_t pt;
        nseg = (shadow_segments == 0) ? 1 : longint'(shadow_segments);
        if (nseg > MAX_SEG)
            nseg = MAX_SEG;
        nctl = shadow_cubic ? 4 : 3;
        d    = shadow_cubic ? 6 * nseg * nseg * nseg : 2 * nseg * nseg;
        for (i = 0; i <= nseg; i++) begin
            j = nseg - i;
            if (shadow_cubic) begin
                w[0] = j * j * j;
                w[1] = 3 * i * i * i - 6 * i * i * nseg + 4 * nseg * nseg * nseg;
                w[2] = -3 * i * i * i + 3 * i * i * nseg + 3 * i * nseg * nseg
                       + nseg * nseg * nseg;
                w[3] = i * i * i;
            end else begin
                w[0] = j * j;
                w[1] = -2 * i * i + 2 * i * nseg + nseg * nseg;
                w[2] = i * i;
                w[3] = 0;
            end
            acc_x = 0;
            acc_y = 0;
            for (k = 0; k < nctl; k++) begin
                cx = f[(2 * k) * CW +: CW];
                cy = f[(2 * k + 1) * CW +: CW];
                acc_x += longint'(cx) * w[k];
                acc_y += longint'(cy) * w[k];
            end
            pt.x = round_to_coord(acc_x, d);
            pt.y = round_to_coord(acc_y, d);
            // pinned endpoints override the curve
            if (shadow_pin && i == 0) begin
                pt.x = f[8 * CW +: CW];
                pt.y = f[9 * CW +: CW];
            end else if (shadow_pin && i == nseg) begin
                pt.x = f[10 * CW +: CW];
                pt.y = f[11 * CW +: CW];
            end
            pt.idx     = i[IDX_W-1:0];
            pt.is_last = (i == nseg);
            pending_points.push_back(pt);
        end
    endtask

    // ---------------- plan building ----------------

    function automatic logic [CW-1:0] pick_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3, 4:    return {{(CW-20){r[19]}}, r[19:0]};   // small magnitude
            default: return r[CW-1:0];
        endcase
    endfunction

    function automatic logic [N_FIELDS*CW-1:0] random_fields();
        logic [N_FIELDS*CW-1:0] f;
        for (int k = 0; k < N_FIELDS; k++)
            f[k * CW +: CW] = pick_coord();
        return f;
    endfunction

    // control x fields, control y fields, pinned points
    function automatic logic [N_FIELDS*CW-1:0] fields_of(input logic [CW-1:0] xv,
                                                         input logic [CW-1:0] yv,
                                                         input logic [CW-1:0] pv);
        logic [N_FIELDS*CW-1:0] f;
        for (int k = 0; k < N_CTRL; k++)
            f[k * CW +: CW] = k[0] ? yv : xv;
        for (int k = N_CTRL; k < N_FIELDS; k++)
            f[k * CW +: CW] = pv;
        return f;
    endfunction

    task automatic add_segment(input logic [N_FIELDS*CW-1:0] f);
        plan_entry_t e;
        e = '{kind: OP_SEGMENT, fields: f, reg_idx: '0, reg_val: '0};
        request_plan.push_back(e);
        total_items++;
    endtask

    task automatic add_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
        plan_entry_t e;
        e = '{kind: OP_REG_WRITE, fields: '0, reg_idx: idx, reg_val: val};
        request_plan.push_back(e);
    endtask

    task automatic add_drain();
        plan_entry_t e;
        e = '{kind: OP_DRAIN, fields: '0, reg_idx: '0, reg_val: '0};
        request_plan.push_back(e);
    endtask

    // ---------------- driver ----------------
    always @(posedge aclk) begin
        plan_entry_t e;
        logic        load_s, load_c;
        if (!aresetn) begin
            s_tvalid        <= 1'b0;
            cfg_valid       <= 1'b0;
            shadow_segments  = bse_pkg::SEGMENTS_RESET;
            shadow_cubic     = 1'b1;
            shadow_pin       = 1'b0;
        end else begin
            // accepted segment request: queue its points
            if (s_tvalid && s_tready) begin
                predict_curve_points(s_tdata[N_FIELDS*CW-1:0]);
                items_accepted++;
            end
            // accepted register write
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    bse_pkg::REG_SEGMENTS:      shadow_segments = cfg_data[IDX_W-1:0];
                    bse_pkg::REG_CUBIC_MODE:    shadow_cubic    = cfg_data[0];
                    bse_pkg::REG_PIN_ENDPOINTS: shadow_pin      = cfg_data[0];
                    default: ;
                endcase
            end
            load_s = 1'b0;
            load_c = 1'b0;
            if ((s_tvalid && !s_tready) || (cfg_valid && !cfg_ready)) begin
                // request still pending
                load_s = s_tvalid;
                load_c = cfg_valid;
            end else if (settle_cnt > 0) begin
                settle_cnt--;
            end else if (request_plan.size() > 0) begin
                e = request_plan[0];
                case (e.kind)
                    OP_SEGMENT: begin
                        if ($urandom_range(99) >= idle_pct(1'b1)) begin
                            void'(request_plan.pop_front());
                            load_s = 1'b1;
                            s_tdata <= S_W'(e.fields);
                        end
                    end
                    OP_REG_WRITE: begin
                        void'(request_plan.pop_front());
                        load_c = 1'b1;
                        cfg_index <= e.reg_idx;
                        cfg_data  <= e.reg_val;
                    end
                    OP_DRAIN: begin
                        // hold off until every point is back, then let the block settle
                        if (pending_points.size() == 0) begin
                            void'(request_plan.pop_front());
                            settle_cnt = SETTLE_CYCLES;
                        end
                    end
                    default: ;
                endcase
            end
            s_tvalid  <= load_s;
            cfg_valid <= load_c;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge aclk) begin
        curve_point_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct(1'b0));
            if (m_tvalid && m_tready) begin
                got.x       = m_tdata[CW-1:0];
                got.y       = m_tdata[2*CW-1:CW];
                got.idx     = m_tdata[2*CW +: IDX_W];
                got.is_last = m_tlast;
                if (pending_points.size() == 0) begin
                    log_mismatch($sformatf("unexpected point idx=%0d x=%h y=%h",
                                           got.idx, got.x, got.y));
                end else begin
                    want = pending_points.pop_front();
                    if (got.x !== want.x)
                        log_mismatch($sformatf("idx %0d out_x got %h exp %h",
                                               want.idx, got.x, want.x));
                    if (got.y !== want.y)
                        log_mismatch($sformatf("idx %0d out_y got %h exp %h",
                                               want.idx, got.y, want.y));
                    if (got.idx !== want.idx)
                        log_mismatch($sformatf("sample_index got %0d exp %0d",
                                               got.idx, want.idx));
                    if (got.is_last !== want.is_last)
                        log_mismatch($sformatf("idx %0d tlast got %b exp %b",
                                               want.idx, got.is_last, want.is_last));
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        logic [N_FIELDS*CW-1:0] f;
        logic [CFG_DATA_W-1:0]  v;
        int                     seg;

        // reset values: 16 intervals, cubic, no pinning; pin fields ignored
        add_segment(fields_of('0, '0, '0));
        add_segment(fields_of(COORD_MAX, COORD_MAX, COORD_MAX));
        add_segment(fields_of(COORD_MIN, COORD_MIN, COORD_MIN));
        add_segment(fields_of(COORD_MAX, COORD_MIN, '0));
        add_segment(random_fields());

        // widest segment count, pinned endpoints at the extreme opposite to the control x values
        add_drain();
        add_reg_write(bse_pkg::REG_SEGMENTS, 32'd63);
        add_reg_write(bse_pkg::REG_PIN_ENDPOINTS, 32'd1);
        add_segment(fields_of(COORD_MAX, COORD_MIN, COORD_MIN));
        add_segment(fields_of(COORD_MIN, COORD_MAX, COORD_MAX));

        // quadratic (upper data bits must be dropped), zero intervals act as one
        add_drain();
        add_reg_write(bse_pkg::REG_CUBIC_MODE, 32'hFFFF_FFFE);
        add_reg_write(bse_pkg::REG_SEGMENTS, 32'hFFFF_FFC0);
        add_segment(random_fields());
        f = fields_of(COORD_MIN, COORD_MIN, '0);
        f[6*CW +: 2*CW] = {COORD_MAX, COORD_MAX};   // c3 ignored in quadratic
        add_segment(f);

        // masked segment count, writes to unmapped indexes, pinning off
        add_drain();
        add_reg_write(bse_pkg::REG_SEGMENTS, 32'hA5A5_A543);
        add_reg_write(REG_UNMAPPED_LO, 32'h0000_003F);
        add_reg_write(REG_UNMAPPED_HI, 32'hFFFF_FFFF);
        add_reg_write(bse_pkg::REG_PIN_ENDPOINTS, 32'h5A5A_5A5A);
        add_segment(random_fields());
        f = fields_of('0, '0, COORD_MAX);
        f[6*CW +: 2*CW] = {COORD_MAX, COORD_MIN};
        add_segment(f);

        // single interval, cubic
        add_drain();
        add_reg_write(bse_pkg::REG_CUBIC_MODE, 32'd1);
        add_reg_write(bse_pkg::REG_SEGMENTS, 32'd1);
        add_segment(random_fields());
        add_segment(fields_of(COORD_MAX, COORD_MAX, COORD_MIN));

        // two intervals, pinned
        add_drain();
        add_reg_write(bse_pkg::REG_PIN_ENDPOINTS, 32'd1);
        add_reg_write(bse_pkg::REG_SEGMENTS, 32'd2);
        add_segment(random_fields());
        add_segment(fields_of(COORD_MIN, COORD_MAX, COORD_MAX));

        // random phases, each with its own register setting; small counts mostly
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            add_drain();
            case ($urandom_range(15))
                0:       seg = MAX_SEG;
                1:       seg = 0;
                2, 3:    seg = $urandom_range(9, 62);
                default: seg = $urandom_range(1, 8);
            endcase
            v = $urandom;
            v[IDX_W-1:0] = seg[IDX_W-1:0];
            add_reg_write(bse_pkg::REG_SEGMENTS, v);
            add_reg_write(bse_pkg::REG_CUBIC_MODE, $urandom);
            add_reg_write(bse_pkg::REG_PIN_ENDPOINTS, $urandom);
            if ($urandom_range(3) == 0)
                add_reg_write(CFG_IDX_W'($urandom_range(3, 255)), $urandom);
            for (int k = 0; k < PHASE_ITEMS; k++)
                add_segment(random_fields());
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // drain the plan, then all expected points, then a quiet tail
        while (request_plan.size() != 0 || s_tvalid || cfg_valid)
            @(posedge aclk);
        while (pending_points.size() != 0)
            @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);

        if (pending_points.size() != 0)
            log_mismatch($sformatf("%0d points never arrived", pending_points.size()));
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
